FILE: sv/bfp_radix2_butterfly_combine_macros.svh
// Assertion macros used by the block's checker.
`ifndef BFP_RADIX2_BUTTERFLY_COMBINE_MACROS_SVH
`define BFP_RADIX2_BUTTERFLY_COMBINE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define BFP_R2BF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfp_r2bf assertion failed");

// Antecedent implies consequent in the following cycle.
`define BFP_R2BF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfp_r2bf assertion failed");

`endif

FILE: sv/bfp_r2bf_pkg.sv
// Types and constants shared by the block floating point butterfly.
package bfp_r2bf_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned EXP_W       = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_EXP_EVEN = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXP_ODD  = 8'd1;

    typedef struct packed {
        logic signed [15:0] even_re;
        logic signed [15:0] even_im;
        logic signed [15:0] odd_re;
        logic signed [15:0] odd_im;
        logic signed [15:0] twiddle_re;
        logic signed [15:0] twiddle_im;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sum_re;
        logic signed [15:0] sum_im;
        logic signed [15:0] diff_re;
        logic signed [15:0] diff_im;
    } t_out_item;

    typedef struct packed {
        logic [EXP_W-1:0] exp_even;
        logic [EXP_W-1:0] exp_odd;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] er;
        logic signed [15:0] ei;
        logic signed [15:0] orr;
        logic signed [15:0] oi;
        logic signed [15:0] wr;
        logic signed [15:0] wi;
    } t_aln;

    typedef struct packed {
        logic signed [15:0] er;
        logic signed [15:0] ei;
        logic signed [17:0] tr;
        logic signed [17:0] ti;
    } t_tw;

endpackage

FILE: sv/bfp_r2bf_align.sv
// Exponent alignment stage: shifts both operands to the common block exponent.
module bfp_r2bf_align (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  bfp_r2bf_pkg::t_in_item i_data,
    input  bfp_r2bf_pkg::t_cfg    i_cfg,
    input  logic                  i_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output bfp_r2bf_pkg::t_aln    o_data
);
    import bfp_r2bf_pkg::*;

    logic             r_valid;
    t_aln             r_data;
    t_aln             n_data;
    logic [EXP_W-1:0] common;
    logic [EXP_W-1:0] sh_e;
    logic [EXP_W-1:0] sh_o;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        common = (i_cfg.exp_even > i_cfg.exp_odd) ? i_cfg.exp_even : i_cfg.exp_odd;
        sh_e   = common - i_cfg.exp_even;
        sh_o   = common - i_cfg.exp_odd;
        n_data.er  = $signed(i_data.even_re) >>> sh_e;
        n_data.ei  = $signed(i_data.even_im) >>> sh_e;
        n_data.orr = $signed(i_data.odd_re) >>> sh_o;
        n_data.oi  = $signed(i_data.odd_im) >>> sh_o;
        n_data.wr  = i_data.twiddle_re;
        n_data.wi  = i_data.twiddle_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/bfp_r2bf_cmul.sv
// Twiddle multiply: a product stage followed by a combine and Q15 rescale stage.
module bfp_r2bf_cmul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bfp_r2bf_pkg::t_aln i_data,
    input  logic               i_ready,
    output logic               o_ready,
    output logic               o_valid,
    output bfp_r2bf_pkg::t_tw  o_data
);
    import bfp_r2bf_pkg::*;

    logic               r_valid_p;
    logic               r_valid_t;
    logic               ready_p;
    logic               ready_t;
    logic signed [15:0] r_er_p;
    logic signed [15:0] r_ei_p;
    logic signed [31:0] r_p_rr;
    logic signed [31:0] r_p_ii;
    logic signed [31:0] r_p_ri;
    logic signed [31:0] r_p_ir;
    logic signed [31:0] n_p_rr;
    logic signed [31:0] n_p_ii;
    logic signed [31:0] n_p_ri;
    logic signed [31:0] n_p_ir;
    logic signed [32:0] n_d_re;
    logic signed [32:0] n_d_im;
    logic signed [32:0] sh_re;
    logic signed [32:0] sh_im;
    t_tw                r_data;

    assign ready_t = !r_valid_t || i_ready;
    assign ready_p = !r_valid_p || ready_t;
    assign o_ready = ready_p;

    always_comb begin
        n_p_rr = i_data.wr * i_data.orr;
        n_p_ii = i_data.wi * i_data.oi;
        n_p_ri = i_data.wr * i_data.oi;
        n_p_ir = i_data.wi * i_data.orr;
        n_d_re = $signed({r_p_rr[31], r_p_rr}) - $signed({r_p_ii[31], r_p_ii});
        n_d_im = $signed({r_p_ri[31], r_p_ri}) + $signed({r_p_ir[31], r_p_ir});
        sh_re  = n_d_re >>> 15;
        sh_im  = n_d_im >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
            r_valid_t <= 1'b0;
        end else begin
            if (ready_p) begin
                r_valid_p <= i_valid;
            end
            if (ready_t) begin
                r_valid_t <= r_valid_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_p && i_valid) begin
            r_er_p <= i_data.er;
            r_ei_p <= i_data.ei;
            r_p_rr <= n_p_rr;
            r_p_ii <= n_p_ii;
            r_p_ri <= n_p_ri;
            r_p_ir <= n_p_ir;
        end
        if (ready_t && r_valid_p) begin
            r_data.er <= r_er_p;
            r_data.ei <= r_ei_p;
            r_data.tr <= sh_re[17:0];
            r_data.ti <= sh_im[17:0];
        end
    end

    assign o_valid = r_valid_t;
    assign o_data  = r_data;

endmodule

FILE: sv/bfp_r2bf_bfly.sv
// Butterfly output stage: sum and difference, halved and saturated to 16 bits.
module bfp_r2bf_bfly (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  bfp_r2bf_pkg::t_tw       i_data,
    input  logic                    i_stall,
    output logic                    o_ready,
    output logic                    o_valid,
    output bfp_r2bf_pkg::t_out_item o_data
);
    import bfp_r2bf_pkg::*;

    localparam logic signed [18:0] SAT_MAX = 19'sd32767;
    localparam logic signed [18:0] SAT_MIN = -19'sd32768;

    function automatic logic [15:0] sat16(input logic signed [18:0] v);
        logic [15:0] res;
        if (v > SAT_MAX) begin
            res = SAT_MAX[15:0];
        end else if (v < SAT_MIN) begin
            res = SAT_MIN[15:0];
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    logic               r_valid;
    t_out_item          r_data;
    t_out_item          n_data;
    logic signed [18:0] er_x;
    logic signed [18:0] ei_x;
    logic signed [18:0] tr_x;
    logic signed [18:0] ti_x;
    logic signed [18:0] s_re;
    logic signed [18:0] s_im;
    logic signed [18:0] d_re;
    logic signed [18:0] d_im;

    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        er_x = $signed({{3{i_data.er[15]}}, i_data.er});
        ei_x = $signed({{3{i_data.ei[15]}}, i_data.ei});
        tr_x = $signed({i_data.tr[17], i_data.tr});
        ti_x = $signed({i_data.ti[17], i_data.ti});
        s_re = (er_x + tr_x) >>> 1;
        s_im = (ei_x + ti_x) >>> 1;
        d_re = (er_x - tr_x) >>> 1;
        d_im = (ei_x - ti_x) >>> 1;
        n_data.sum_re  = sat16(s_re);
        n_data.sum_im  = sat16(s_im);
        n_data.diff_re = sat16(d_re);
        n_data.diff_im = sat16(d_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/bfp_radix2_butterfly_combine.sv
// Radix-2 block floating point butterfly, top level with exponent registers.
// Each accepted request passes through the align, product, rescale and butterfly
// register stages to its result; one request is taken every cycle while o_in_stall is low.
// A stalled output holds each stage that is full, and a bubble in any stage is filled.
// Synchronous active-low reset empties every stage and sets both exponents to zero.
// The configuration port is always ready.
module bfp_radix2_butterfly_combine (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  bfp_r2bf_pkg::t_in_item                 i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output bfp_r2bf_pkg::t_out_item                o_out_data,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [bfp_r2bf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bfp_r2bf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bfp_r2bf_pkg::*;

    logic [EXP_W-1:0] r_exp_even;
    logic [EXP_W-1:0] r_exp_odd;
    t_cfg             cfg;
    logic             aln_ready;
    logic             aln_valid;
    t_aln             aln_data;
    logic             mul_ready;
    logic             mul_valid;
    t_tw              mul_data;
    logic             bfl_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_even <= '0;
            r_exp_odd  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_EXP_EVEN: r_exp_even <= i_cfg_data[EXP_W-1:0];
                REG_EXP_ODD:  r_exp_odd  <= i_cfg_data[EXP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.exp_even = r_exp_even;
    assign cfg.exp_odd  = r_exp_odd;
    assign o_in_stall   = !aln_ready;

    bfp_r2bf_align u_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (cfg),
        .i_ready (mul_ready),
        .o_ready (aln_ready),
        .o_valid (aln_valid),
        .o_data  (aln_data)
    );

    bfp_r2bf_cmul u_cmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (aln_valid),
        .i_data  (aln_data),
        .i_ready (bfl_ready),
        .o_ready (mul_ready),
        .o_valid (mul_valid),
        .o_data  (mul_data)
    );

    bfp_r2bf_bfly u_bfly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .i_data  (mul_data),
        .i_stall (i_out_stall),
        .o_ready (bfl_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

FILE: sv/bfp_r2bf_checker.sv
// Port-level checker for the butterfly and the bind that attaches it.
`include "bfp_radix2_butterfly_combine_macros.svh"

module bfp_r2bf_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input bfp_r2bf_pkg::t_out_item o_out_data
);
    import bfp_r2bf_pkg::*;

    `BFP_R2BF_ASSERT_NXT(a_out_valid_held, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `BFP_R2BF_ASSERT_NXT(a_out_data_held, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))
    `BFP_R2BF_ASSERT_IMP(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `BFP_R2BF_ASSERT_IMP(a_empty_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)

endmodule

bind bfp_radix2_butterfly_combine bfp_r2bf_checker u_bfp_r2bf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
